// ===== rtl/okl_pkg.sv =====
// Shared constants and types for the ordered key list with ring neighbours.
`default_nettype none
package okl_pkg;

  localparam int DEPTH = 16;
  localparam int KEY_W = 16;
  localparam int ACT_W = 2;
  localparam int ST_W  = 2;
  localparam int S_DATA_W = ((ACT_W + KEY_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((KEY_W + ST_W + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_NEXT   = 2'd2,
    ACT_PREV   = 2'd3
  } act_t;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_EXEC,
    S_DONE
  } state_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic             match_load;
    logic             search_ok;
    logic             exec_en;
    act_t             op;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/ordered_key_list_ring_neighbours.sv =====
// Top level: ordered key list with remove and circular neighbour lookup.
//
// Input channel s_*: one item is an action (append, remove, next, prev) and a
// 16-bit key. Output channel m_*: one result item per input item, carrying the
// neighbour key (0 for append/remove or when nothing is found) and a status
// (ok, missing/null, full).
// The list lives in a row of DEPTH cells, head in cell 0. Each item walks a
// four-state sequencer: accept, match (every cell compares its key), execute
// (first match resolved along the cell row, cells shift or fill, neighbour
// picked), done (result moved into the output register).
// The sequencer takes no new item until the last one has left its done state;
// the result is registered in execute and moved to the output register in done.
// The output register holds a finished result while m_tready is low; the
// sequencer waits in its done state until that register frees up, and
// s_tready stays low meanwhile.
// rst (synchronous) empties the list and drops any pending result.
`default_nettype none
module ordered_key_list_ring_neighbours (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // [1:0] action, [17:2] key_id, [23:18] zero
  input  wire logic [okl_pkg::S_DATA_W-1:0] s_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // [15:0] neighbour_id, [17:16] status, [23:18] zero
  output logic [okl_pkg::M_DATA_W-1:0]      m_tdata
);

  localparam int D = okl_pkg::DEPTH;
  localparam int W = okl_pkg::KEY_W;

  okl_pkg::state_t  state, state_next;
  okl_pkg::act_t    op;
  logic [W-1:0]     req_key;
  okl_pkg::cell_ctl_t ctl;

  logic [W-1:0]            res_nb;
  logic [okl_pkg::ST_W-1:0] res_st;
  logic [W-1:0]            nb_next;
  logic [okl_pkg::ST_W-1:0] st_next;
  logic [W-1:0]            out_nb;
  logic [okl_pkg::ST_W-1:0] out_st;

  logic [D-1:0]  c_valid, c_hit, c_first, c_tail_first;
  logic [W-1:0]  c_key     [D];
  logic [W-1:0]  c_sel_key [D];
  logic          wrap;
  logic          load_out;

  assign s_tready = (state == okl_pkg::S_IDLE);
  assign load_out = (state == okl_pkg::S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    ctl.match_load = (state == okl_pkg::S_MATCH);
    ctl.search_ok  = (op != okl_pkg::ACT_APPEND) &&
                     !((op == okl_pkg::ACT_REMOVE) && (req_key == '0));
    ctl.exec_en    = (state == okl_pkg::S_EXEC);
    ctl.op         = op;
    ctl.key        = req_key;
  end

  assign wrap = |c_tail_first;

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic         lv, lh, lf, rv, rf, ws;
    logic [W-1:0] rk;
    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign lh = 1'b0;
      assign lf = 1'b0;
      assign ws = wrap;
    end else begin : g_body
      assign lv = c_valid[i-1];
      assign lh = c_hit[i-1];
      assign lf = c_first[i-1];
      assign ws = 1'b0;
    end
    if (i == D - 1) begin : g_tail
      assign rv = 1'b0;
      assign rf = 1'b0;
      assign rk = '0;
    end else begin : g_mid
      assign rv = c_valid[i+1];
      assign rf = c_first[i+1];
      assign rk = c_key[i+1];
    end
    okl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .left_valid (lv),
      .left_hit   (lh),
      .left_first (lf),
      .right_valid(rv),
      .right_key  (rk),
      .right_first(rf),
      .wrap_sel   (ws),
      .valid      (c_valid[i]),
      .key        (c_key[i]),
      .hit        (c_hit[i]),
      .first      (c_first[i]),
      .tail_first (c_tail_first[i]),
      .sel_key    (c_sel_key[i])
    );
  end

  // at most one cell drives a nonzero neighbour key
  always_comb begin
    nb_next = '0;
    for (int i = 0; i < D; i++) begin
      nb_next = nb_next | c_sel_key[i];
    end
  end

  always_comb begin
    case (op)
      okl_pkg::ACT_APPEND: st_next = c_valid[D-1] ? okl_pkg::ST_FULL : okl_pkg::ST_OK;
      default:             st_next = c_hit[D-1] ? okl_pkg::ST_OK : okl_pkg::ST_MISSING;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      okl_pkg::S_IDLE:  if (s_tvalid) state_next = okl_pkg::S_MATCH;
      okl_pkg::S_MATCH: state_next = okl_pkg::S_EXEC;
      okl_pkg::S_EXEC:  state_next = okl_pkg::S_DONE;
      okl_pkg::S_DONE:  if (load_out) state_next = okl_pkg::S_IDLE;
      default:          state_next = okl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= okl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op      <= okl_pkg::act_t'(s_tdata[okl_pkg::ACT_W-1:0]);
      req_key <= s_tdata[okl_pkg::ACT_W +: W];
    end
    if (state == okl_pkg::S_EXEC) begin
      res_nb <= nb_next;
      res_st <= st_next;
    end
    if (load_out) begin
      out_nb <= res_nb;
      out_st <= res_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {{(okl_pkg::M_DATA_W - W - okl_pkg::ST_W){1'b0}}, out_st, out_nb};

endmodule
`default_nettype wire

// ===== rtl/okl_cell.sv =====
// One list slot: stored key, valid bit, match flag and neighbour logic.
`default_nettype none
module okl_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire okl_pkg::cell_ctl_t        ctl,
  input  wire logic                      left_valid,
  input  wire logic                      left_hit,
  input  wire logic                      left_first,
  input  wire logic                      right_valid,
  input  wire logic [okl_pkg::KEY_W-1:0] right_key,
  input  wire logic                      right_first,
  input  wire logic                      wrap_sel,
  output logic                           valid,
  output logic [okl_pkg::KEY_W-1:0]      key,
  output logic                           hit,
  output logic                           first,
  output logic                           tail_first,
  output logic [okl_pkg::KEY_W-1:0]      sel_key
);

  logic match;
  logic sel;

  assign hit        = left_hit | match;
  assign first      = match & ~left_hit;
  assign tail_first = first & ~right_valid;

  always_comb begin
    case (ctl.op)
      okl_pkg::ACT_NEXT: sel = (left_first & valid) | wrap_sel;
      okl_pkg::ACT_PREV: sel = right_first;
      default:           sel = 1'b0;
    endcase
  end

  assign sel_key = sel ? key : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.match_load) begin
      match <= ctl.search_ok & valid & (key == ctl.key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.exec_en) begin
      case (ctl.op)
        okl_pkg::ACT_APPEND: begin
          if (left_valid && !valid) begin
            valid <= 1'b1;
          end
        end
        okl_pkg::ACT_REMOVE: begin
          // everything from the first match onward moves one slot toward the head
          if (hit) begin
            valid <= right_valid;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec_en) begin
      case (ctl.op)
        okl_pkg::ACT_APPEND: begin
          if (left_valid && !valid) begin
            key <= ctl.key;
          end
        end
        okl_pkg::ACT_REMOVE: begin
          if (hit) begin
            key <= right_key;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== bench/ordered_key_list_ring_neighbours_tb.sv =====
// Self-checking testbench for the ordered key list with ring neighbour lookup.
`timescale 1ns / 1ps
module ordered_key_list_ring_neighbours_tb;
  import okl_pkg::*;

  localparam int LIST_SLOTS   = okl_pkg::DEPTH;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int POOL_SIZE    = 6;

  typedef struct {
    act_t             action;
    logic [KEY_W-1:0] key;
    bit               wait_idle;   // hold off until every result is back
  } request_t;

  typedef struct {
    logic [KEY_W-1:0] neighbour;
    logic [ST_W-1:0]  status;
  } result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  request_t pending_requests[$];
  result_t  expected_results[$];
  request_t active_req;

  // Shadow copy of the list, head in slot 0
  logic [KEY_W-1:0] list_keys[LIST_SLOTS];
  int               list_len = 0;

  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  int errors = 0;
  int cycles = 0;
  int src_wait = 0;
  int src_calm = 0;
  int snk_wait = 0;
  int snk_calm = 0;

  ordered_key_list_ring_neighbours u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // Applies one request to the shadow list and returns the result it should give.
  function automatic result_t apply_request(input request_t req);
    result_t res;
    int      pos;
    res.neighbour = '0;
    res.status    = ST_OK;
    pos = -1;
    for (int i = 0; i < list_len; i++)
      if (pos < 0 && list_keys[i] == req.key) pos = i;
    case (req.action)
      ACT_APPEND: begin
        if (list_len >= LIST_SLOTS) begin
          res.status = ST_FULL;
        end else begin
          list_keys[list_len] = req.key;
          list_len++;
        end
      end
      ACT_REMOVE: begin
        // null key is never removed, even if one is stored
        if (req.key == '0 || pos < 0) begin
          res.status = ST_MISSING;
        end else begin
          for (int i = pos; i < list_len - 1; i++) list_keys[i] = list_keys[i + 1];
          list_len--;
        end
      end
      ACT_NEXT: begin
        if (pos < 0) res.status = ST_MISSING;
        else if (pos + 1 >= list_len) res.neighbour = list_keys[0];
        else res.neighbour = list_keys[pos + 1];
      end
      default: begin
        if (pos < 0) res.status = ST_MISSING;
        else if (pos > 0) res.neighbour = list_keys[pos - 1];
      end
    endcase
    return res;
  endfunction

  // Mostly short gaps, some long, and now and then a run with none at all.
  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("ERROR @%0d: %s got 0x%0h want 0x%0h", cycles, what, got_v, want_v);
    errors++;
  endtask

  task automatic add_request(input act_t a, input logic [KEY_W-1:0] k, input bit w);
    request_t req;
    req.action    = a;
    req.key       = k;
    req.wait_idle = w;
    pending_requests.push_back(req);
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(apply_request(active_req));
      if (s_tvalid && !s_tready) begin
        // hold the item until it is taken
      end else if (src_wait > 0) begin
        src_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_requests.size() == 0 ||
                   (pending_requests[0].wait_idle && expected_results.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else begin
        active_req = pending_requests.pop_front();
        s_tdata  <= S_DATA_W'({active_req.key, active_req.action});
        s_tvalid <= 1'b1;
        src_wait = pick_gap(src_calm);
      end
    end
  end

  // Monitor and sink
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.neighbour = m_tdata[KEY_W-1:0];
      got.status    = m_tdata[KEY_W+ST_W-1:KEY_W];
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item outstanding", int'(m_tdata), 0);
      end else begin
        want = expected_results.pop_front();
        if (got.neighbour !== want.neighbour)
          report_mismatch("neighbour_id", got.neighbour, want.neighbour);
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
      end
    end
    if (snk_wait > 0) begin
      snk_wait--;
      m_tready <= 1'b0;
    end else if ((m_tvalid && m_tready) || $urandom_range(0, 15) == 0) begin
      snk_wait = pick_gap(snk_calm);
      m_tready <= (snk_wait == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int       random_count;
    int       phase_no;
    int       phase_len;
    int       mode;
    int       r;
    act_t     a;
    logic [KEY_W-1:0] k;

    // Directed: empty list, null key, single entry, duplicates, head and tail
    add_request(ACT_REMOVE, 16'h0001, 1'b0);
    add_request(ACT_NEXT,   16'h0000, 1'b0);
    add_request(ACT_PREV,   16'h0000, 1'b0);
    add_request(ACT_APPEND, 16'hA5A5, 1'b0);
    add_request(ACT_NEXT,   16'hA5A5, 1'b0);   // lone entry wraps to itself
    add_request(ACT_PREV,   16'hA5A5, 1'b0);   // head has no predecessor
    add_request(ACT_APPEND, 16'h0000, 1'b0);
    add_request(ACT_APPEND, 16'hFFFF, 1'b0);
    add_request(ACT_APPEND, 16'h5A5A, 1'b0);
    add_request(ACT_APPEND, 16'hFFFF, 1'b0);
    add_request(ACT_NEXT,   16'h0000, 1'b0);
    add_request(ACT_PREV,   16'h0000, 1'b0);
    add_request(ACT_NEXT,   16'hFFFF, 1'b0);   // first of two copies
    add_request(ACT_PREV,   16'hFFFF, 1'b0);
    add_request(ACT_REMOVE, 16'h0000, 1'b0);   // null rejected though stored
    add_request(ACT_REMOVE, 16'hFFFF, 1'b0);
    add_request(ACT_NEXT,   16'hFFFF, 1'b0);   // now the tail, wraps
    add_request(ACT_REMOVE, 16'h1234, 1'b0);
    add_request(ACT_PREV,   16'h1234, 1'b0);
    add_request(ACT_REMOVE, 16'hA5A5, 1'b0);   // remove the head
    add_request(ACT_PREV,   16'h5A5A, 1'b0);
    add_request(ACT_NEXT,   16'h0000, 1'b0);

    // Random phases: grow toward full, shrink toward empty, or mixed
    random_count = 0;
    phase_no = 0;
    while (random_count < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 120);
      mode = $urandom_range(0, 2);
      for (int j = 0; j < POOL_SIZE; j++) key_pool[j] = KEY_W'($urandom_range(0, 65535));
      if ($urandom_range(0, 3) == 0) key_pool[0] = '0;
      if ($urandom_range(0, 3) == 0) key_pool[1] = '1;
      for (int n = 0; n < phase_len; n++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0: a = (r < 60) ? ACT_APPEND : (r < 75) ? ACT_REMOVE : (r < 88) ? ACT_NEXT : ACT_PREV;
          1: a = (r < 20) ? ACT_APPEND : (r < 65) ? ACT_REMOVE : (r < 83) ? ACT_NEXT : ACT_PREV;
          default:
             a = (r < 35) ? ACT_APPEND : (r < 55) ? ACT_REMOVE : (r < 78) ? ACT_NEXT : ACT_PREV;
        endcase
        if ($urandom_range(0, 9) == 0) k = KEY_W'($urandom_range(0, 65535));
        else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        add_request(a, k, n == 0 && (phase_no == 0 || $urandom_range(0, 3) == 0));
        random_count++;
      end
      phase_no++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), 0);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== ordered_key_list_ring_neighbours.f =====
rtl/okl_pkg.sv
rtl/okl_cell.sv
rtl/ordered_key_list_ring_neighbours.sv
bench/ordered_key_list_ring_neighbours_tb.sv
